// ===== design/swsd_pkg.sv =====
package swsd_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int CFG_W             = 20;
    localparam int CFG_IDX_W         = 2;
    localparam int MIN_STABLE_COUNT  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SIMULATED_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_MS           = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_MS         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STABILITY_LIMIT_NV = 2'd3;

    localparam logic [CFG_W-1:0] STALE_MS_RESET   = 20'd2000;
    localparam logic [CFG_W-1:0] HISTORY_MS_RESET = 20'd10000;
    localparam logic [CFG_W-1:0] LIMIT_NV_RESET   = 20'd10000;

    typedef struct packed {
        logic               action;
        logic [31:0]        sequence_req;
        logic [31:0]        sample_time_ms;
        logic [7:0]         gain;
        logic signed [31:0] voltage_nv;
        logic               voltage_valid;
        logic               simulated;
        logic               warmed;
        logic [7:0]         sensor_faults_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] mean_nv;
        logic [31:0]        peak_to_peak_nv;
        logic               stable;
        logic [7:0]         sensor_faults_out;
        logic               nonfinite_fault;
        logic               transport_fault;
        logic [6:0]         window_fill;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic age_drop;
        logic full_drop;
        logic insert;
        logic scan;
        logic div_start;
        logic div_take;
        logic mul1;
        logic mul2;
        logic judge;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic is_dup;
        logic is_reject;
        logic fill_gt1;
        logic age_old;
        logic full;
        logic scan_done;
        logic div_done;
    } status_t;

endpackage

// ===== design/swsd_div.sv =====
module swsd_div #(
    parameter int DW = 38,
    parameter int VW = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW-1:0] dvs_reg;
    logic [VW+1:0] trial;

    // restoring step: shift in next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[DW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DW);
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            if (trial >= {2'b00, dvs_reg}) begin
                rem_reg <= (VW+1)'(trial - {2'b00, dvs_reg});
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_reg <= trial[VW:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== design/swsd_ctrl.sv =====
module swsd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  swsd_pkg::status_t sts,
    output swsd_pkg::cmd_t    cmd
);
    import swsd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_AGE_RD, S_AGE_CMP, S_FULL, S_INS, S_SCAN,
        S_DIV_GO, S_DIV_WAIT, S_MUL1, S_MUL2, S_JUDGE, S_OUT
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd           = '0;
        cmd.capture   = (state_reg == S_IDLE) && s_valid;
        cmd.eval      = (state_reg == S_EVAL);
        cmd.age_drop  = (state_reg == S_AGE_CMP) && sts.age_old;
        cmd.full_drop = (state_reg == S_FULL) && sts.full;
        cmd.insert    = (state_reg == S_INS);
        cmd.scan      = (state_reg == S_SCAN);
        cmd.div_start = (state_reg == S_DIV_GO);
        cmd.div_take  = (state_reg == S_DIV_WAIT) && sts.div_done;
        cmd.mul1      = (state_reg == S_MUL1);
        cmd.mul2      = (state_reg == S_MUL2);
        cmd.judge     = (state_reg == S_JUDGE);
        cmd.load_out  = (state_reg == S_OUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if ((state_reg == S_OUT) && out_free) m_valid_reg <= 1'b1;
            else if (m_ready)                     m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:     if (s_valid) state_reg <= S_EVAL;
                S_EVAL: begin
                    priority if (sts.is_clear || sts.is_dup) state_reg <= S_IDLE;
                    else if (sts.is_reject)                  state_reg <= S_OUT;
                    else                                     state_reg <= S_AGE_RD;
                end
                S_AGE_RD:   state_reg <= sts.fill_gt1 ? S_AGE_CMP : S_FULL;
                S_AGE_CMP:  state_reg <= sts.age_old ? S_AGE_RD : S_FULL;
                S_FULL:     state_reg <= S_INS;
                S_INS:      state_reg <= S_SCAN;
                S_SCAN:     if (sts.scan_done) state_reg <= S_DIV_GO;
                S_DIV_GO:   state_reg <= S_DIV_WAIT;
                S_DIV_WAIT: if (sts.div_done) state_reg <= S_MUL1;
                S_MUL1:     state_reg <= S_MUL2;
                S_MUL2:     state_reg <= S_JUDGE;
                S_JUDGE:    state_reg <= S_OUT;
                S_OUT:      if (out_free) state_reg <= S_IDLE;
                default:    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/swsd_dp.sv =====
module swsd_dp #(
    parameter int HISTORY_DEPTH = swsd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  swsd_pkg::in_item_t              s_data,
    output swsd_pkg::out_item_t             m_data,
    input  logic                            cfg_we,
    input  logic [swsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swsd_pkg::CFG_W-1:0]      cfg_data,
    input  swsd_pkg::cmd_t                  cmd,
    output swsd_pkg::status_t               sts
);
    import swsd_pkg::*;

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int MAG_W = 32 + $clog2(HISTORY_DEPTH);
    localparam int SUM_W = MAG_W + 1;
    localparam int PW = SUM_W + FILL_W + 2;

    logic            sim_mode_reg;
    logic [CFG_W-1:0] stale_reg, hist_reg, limit_reg;

    in_item_t        item_reg;
    logic            present_reg;
    logic [31:0]     last_seq_reg, last_time_reg;
    logic [7:0]      last_gain_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [PTR_W-1:0]  oldest_reg;

    logic [31:0]        slot_time [HISTORY_DEPTH];
    logic signed [31:0] slot_volt [HISTORY_DEPTH];
    logic [31:0]        t_rd_reg;
    logic signed [31:0] v_rd_reg;

    logic [FILL_W-1:0] scan_idx_reg, pend_idx_reg;
    logic              pend_reg;
    logic signed [31:0] low_reg, high_reg;
    logic signed [SUM_W-1:0] sum_reg, early_reg, late_reg;
    logic [31:0]       t0_reg;
    logic signed [31:0] mean_reg;
    logic [31:0]       p2p_reg;
    logic              stable_reg;
    logic [FILL_W-1:0] a_reg, b_reg;
    logic signed [PW-1:0] pe_reg, pl_reg;
    logic [PW-1:0]     mag_reg, rhs1_reg, rhs2_reg;
    out_item_t         out_reg;

    logic transport, rejected, gap, dup;
    logic [31:0] age_dt, span_dt;
    logic [FILL_W-1:0] rd_idx;
    logic [PTR_W-1:0]  rd_addr, wr_addr;
    logic [MAG_W-1:0]  sum_abs, quotient;
    logic              div_done;
    logic signed [PW-1:0] diff;

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                input logic [FILL_W-1:0] idx);
        logic [FILL_W:0] s;
        s = (FILL_W+1)'(base) + (FILL_W+1)'(idx);
        if (s >= (FILL_W+1)'(HISTORY_DEPTH)) s = s - (FILL_W+1)'(HISTORY_DEPTH);
        return s[PTR_W-1:0];
    endfunction

    assign transport = item_reg.simulated != sim_mode_reg;
    assign rejected  = (item_reg.sensor_faults_in != 8'd0) || !item_reg.voltage_valid
                       || transport || !item_reg.warmed;
    assign dup       = present_reg && (item_reg.sequence_req == last_seq_reg);
    assign gap       = present_reg && (((item_reg.sample_time_ms - last_time_reg) >
                       {12'd0, stale_reg}) || (item_reg.gain != last_gain_reg));
    assign age_dt    = item_reg.sample_time_ms - t_rd_reg;
    assign span_dt   = item_reg.sample_time_ms - t0_reg;

    assign rd_idx  = cmd.scan ? scan_idx_reg : FILL_W'(1);
    assign rd_addr = slot_of(oldest_reg, rd_idx);
    assign wr_addr = slot_of(oldest_reg, fill_reg);

    assign sts.is_clear  = item_reg.action;
    assign sts.is_dup    = dup;
    assign sts.is_reject = rejected;
    assign sts.fill_gt1  = fill_reg > FILL_W'(1);
    assign sts.age_old   = age_dt >= {12'd0, hist_reg};
    assign sts.full      = fill_reg >= FILL_W'(HISTORY_DEPTH);
    assign sts.scan_done = (scan_idx_reg == fill_reg) && !pend_reg;
    assign sts.div_done  = div_done;

    assign sum_abs = sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : sum_reg[MAG_W-1:0];
    assign diff    = pe_reg - pl_reg;

    swsd_div #(.DW(MAG_W), .VW(FILL_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_abs),
        .divisor  (fill_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        t_rd_reg <= slot_time[rd_addr];
        v_rd_reg <= slot_volt[rd_addr];
        if (cmd.insert) begin
            slot_time[wr_addr] <= item_reg.sample_time_ms;
            slot_volt[wr_addr] <= item_reg.voltage_nv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sim_mode_reg  <= 1'b0;
            stale_reg     <= STALE_MS_RESET;
            hist_reg      <= HISTORY_MS_RESET;
            limit_reg     <= LIMIT_NV_RESET;
            present_reg   <= 1'b0;
            last_seq_reg  <= '0;
            last_time_reg <= '0;
            last_gain_reg <= '0;
            fill_reg      <= '0;
            oldest_reg    <= '0;
            pend_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_SIMULATED_MODE:     sim_mode_reg <= cfg_data[0];
                    REG_STALE_MS:           stale_reg    <= cfg_data;
                    REG_HISTORY_MS:         hist_reg     <= cfg_data;
                    REG_STABILITY_LIMIT_NV: limit_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.eval) begin
                if (item_reg.action) begin
                    fill_reg    <= '0;
                    present_reg <= 1'b0;
                end else if (!dup) begin
                    last_seq_reg  <= item_reg.sequence_req;
                    last_time_reg <= item_reg.sample_time_ms;
                    last_gain_reg <= item_reg.gain;
                    present_reg   <= 1'b1;
                    if (gap || rejected) fill_reg <= '0;
                end
            end
            if (cmd.age_drop || cmd.full_drop) begin
                oldest_reg <= slot_of(oldest_reg, FILL_W'(1));
                fill_reg   <= fill_reg - FILL_W'(1);
            end
            if (cmd.insert) begin
                fill_reg     <= fill_reg + FILL_W'(1);
                scan_idx_reg <= '0;
                pend_reg     <= 1'b0;
            end
            if (cmd.scan) begin
                if (scan_idx_reg < fill_reg) begin
                    scan_idx_reg <= scan_idx_reg + FILL_W'(1);
                    pend_idx_reg <= scan_idx_reg;
                    pend_reg     <= 1'b1;
                end else begin
                    pend_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) item_reg <= s_data;
        if (cmd.eval) begin
            mean_reg   <= item_reg.voltage_valid ? item_reg.voltage_nv : 32'sd0;
            p2p_reg    <= '0;
            stable_reg <= 1'b0;
        end
        if (cmd.insert) begin
            low_reg   <= item_reg.voltage_nv;
            high_reg  <= item_reg.voltage_nv;
            sum_reg   <= '0;
            early_reg <= '0;
            late_reg  <= '0;
        end
        if (cmd.scan && pend_reg) begin
            if (v_rd_reg < low_reg)  low_reg  <= v_rd_reg;
            if (v_rd_reg > high_reg) high_reg <= v_rd_reg;
            sum_reg <= sum_reg + SUM_W'(v_rd_reg);
            if (pend_idx_reg < (fill_reg >> 1)) early_reg <= early_reg + SUM_W'(v_rd_reg);
            else                                 late_reg  <= late_reg + SUM_W'(v_rd_reg);
            if (pend_idx_reg == '0) t0_reg <= t_rd_reg;
        end
        if (cmd.div_take) begin
            mean_reg <= sum_reg[SUM_W-1] ? -$signed(quotient[31:0]) : $signed(quotient[31:0]);
            p2p_reg  <= 32'(high_reg - low_reg);
            a_reg    <= fill_reg >> 1;
            b_reg    <= fill_reg - (fill_reg >> 1);
        end
        if (cmd.mul1) begin
            pe_reg   <= PW'(early_reg) * PW'($signed({1'b0, b_reg}));
            pl_reg   <= PW'(late_reg) * PW'($signed({1'b0, a_reg}));
            rhs1_reg <= PW'(limit_reg) * PW'(a_reg);
        end
        if (cmd.mul2) begin
            mag_reg  <= diff[PW-1] ? PW'(-diff) : PW'(diff);
            rhs2_reg <= rhs1_reg * PW'(b_reg);
        end
        if (cmd.judge) begin
            stable_reg <= (fill_reg >= FILL_W'(MIN_STABLE_COUNT))
                          && (span_dt >= {12'd0, hist_reg})
                          && (p2p_reg <= {12'd0, limit_reg})
                          && ({mag_reg[PW-2:0], 1'b0} <= rhs2_reg);
        end
        if (cmd.load_out) begin
            out_reg.mean_nv           <= mean_reg;
            out_reg.peak_to_peak_nv   <= p2p_reg;
            out_reg.stable            <= stable_reg;
            out_reg.sensor_faults_out <= item_reg.sensor_faults_in;
            out_reg.nonfinite_fault   <= !item_reg.voltage_valid;
            out_reg.transport_fault   <= transport;
            out_reg.window_fill       <= 7'(fill_reg);
        end
    end

    assign m_data = out_reg;
endmodule

// ===== design/sample_window_stability_detector_unit.sv =====
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  in_item_t: one sample or a clear action
// m_       out        m_valid / m_ready  out_item_t: window summary for one sample
// cfg_     in         cfg_we             cfg_index selects the register, cfg_data
//
// One sample at a time: s_ready is high only while the controller idles.
// A windowed sample's run time is set by the drops, the memory walk over the fill
// and the bit-serial mean divider, which is 32 + log2 depth bits wide.
// Rejected samples skip the window work; clears and repeats end without a result.
// Reset is synchronous on aresetn low; the ring memory is not cleared.
// The result register holds the transfer while m_ready is low; the next sample
// is accepted meanwhile and stalls only at its own result.
module sample_window_stability_detector_unit #(
    parameter int HISTORY_DEPTH = swsd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  swsd_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output swsd_pkg::out_item_t             m_data,
    input  logic                            cfg_we,
    input  logic [swsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [swsd_pkg::CFG_W-1:0]      cfg_data
);
    import swsd_pkg::*;

    // commands from the sequencer, status back from the datapath
    cmd_t    cmd;
    status_t sts;

    swsd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // window ring, accumulators, divider and drift multipliers
    swsd_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );
endmodule

// ===== tb/window_checker.sv =====
`timescale 1ns / 100ps

module window_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  swsd_pkg::in_item_t             s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  swsd_pkg::out_item_t            m_data,
    input  logic                           cfg_we,
    input  logic [swsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swsd_pkg::CFG_W-1:0]     cfg_data,
    output int                             errors,
    output int                             pending
);
    import swsd_pkg::*;

    localparam int DEPTH = HISTORY_DEPTH_DEF;

    // shadow configuration
    logic             sh_mode;
    logic [CFG_W-1:0] sh_stale;
    logic [CFG_W-1:0] sh_hist;
    logic [CFG_W-1:0] sh_limit;

    // shadow window state
    logic        have_sample;
    logic [31:0] prev_seq;
    logic [31:0] prev_time;
    logic [7:0]  prev_gain;
    int          fill;
    int          head;
    logic [31:0] ring_time [DEPTH];
    longint      ring_volt [DEPTH];
    int          err_count = 0;

    out_item_t   expected_summaries[$];

    function automatic int ring_at(int i);
        return (head + i) % DEPTH;
    endfunction

    task automatic predict_summary(input in_item_t it);
        out_item_t   res;
        logic        gap, mismatch, rejected;
        logic [31:0] age;
        longint      v, lo, hi, sum, early, late, a, b, d, mag, p2p;
        int          n;
        res = '0;
        if (it.action) begin
            fill = 0;
            have_sample = 1'b0;
            return;
        end
        if (have_sample && it.sequence_req == prev_seq) return;
        age = it.sample_time_ms - prev_time;
        gap = have_sample && (age > {12'd0, sh_stale} || it.gain != prev_gain);
        prev_seq = it.sequence_req;
        prev_time = it.sample_time_ms;
        prev_gain = it.gain;
        have_sample = 1'b1;
        mismatch = it.simulated != sh_mode;
        rejected = it.sensor_faults_in != 0 || !it.voltage_valid || mismatch || !it.warmed;
        if (gap || rejected) fill = 0;
        v = longint'(it.voltage_nv);
        if (rejected) begin
            res.mean_nv = it.voltage_valid ? it.voltage_nv : 32'sd0;
        end else begin
            // age out while the second oldest is past the window span
            while (fill > 1) begin
                age = it.sample_time_ms - ring_time[ring_at(1)];
                if (age < {12'd0, sh_hist}) break;
                head = (head + 1) % DEPTH;
                fill--;
            end
            if (fill >= DEPTH) begin
                head = (head + 1) % DEPTH;
                fill--;
            end
            ring_time[ring_at(fill)] = it.sample_time_ms;
            ring_volt[ring_at(fill)] = v;
            fill++;
            n = fill;
            lo = v;
            hi = v;
            sum = 0;
            early = 0;
            late = 0;
            for (int i = 0; i < n; i++) begin
                if (ring_volt[ring_at(i)] < lo) lo = ring_volt[ring_at(i)];
                if (ring_volt[ring_at(i)] > hi) hi = ring_volt[ring_at(i)];
                sum += ring_volt[ring_at(i)];
                if (i < n / 2) early += ring_volt[ring_at(i)];
                else late += ring_volt[ring_at(i)];
            end
            p2p = hi - lo;
            res.mean_nv = 32'(sum / n);
            res.peak_to_peak_nv = 32'(p2p);
            age = it.sample_time_ms - ring_time[ring_at(0)];
            if (n >= MIN_STABLE_COUNT && age >= {12'd0, sh_hist}) begin
                a = n / 2;
                b = n - a;
                d = early * b - late * a;
                mag = d < 0 ? -d : d;
                res.stable = p2p <= longint'(sh_limit) &&
                             mag * 2 <= longint'(sh_limit) * a * b;
            end
        end
        res.sensor_faults_out = it.sensor_faults_in;
        res.nonfinite_fault = !it.voltage_valid;
        res.transport_fault = mismatch;
        res.window_fill = 7'(fill);
        expected_summaries.push_back(res);
    endtask

    assign pending = expected_summaries.size();
    assign errors  = err_count;

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            sh_mode = 1'b0;
            sh_stale = STALE_MS_RESET;
            sh_hist = HISTORY_MS_RESET;
            sh_limit = LIMIT_NV_RESET;
            have_sample = 1'b0;
            prev_seq = '0;
            prev_time = '0;
            prev_gain = '0;
            fill = 0;
            head = 0;
            expected_summaries.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SIMULATED_MODE:     sh_mode = cfg_data[0];
                    REG_STALE_MS:           sh_stale = cfg_data;
                    REG_HISTORY_MS:         sh_hist = cfg_data;
                    REG_STABILITY_LIMIT_NV: sh_limit = cfg_data;
                    default: ;
                endcase
            end
            // compare before predicting: a result never belongs to this edge's input
            if (m_valid && m_ready) begin
                if (expected_summaries.size() == 0) begin
                    $error("unexpected result transfer mean_nv=%0d", m_data.mean_nv);
                    err_count++;
                end else begin
                    want = expected_summaries.pop_front();
                    if (m_data.mean_nv !== want.mean_nv) begin
                        $error("mean_nv expected %0d got %0d", want.mean_nv, m_data.mean_nv);
                        err_count++;
                    end
                    if (m_data.peak_to_peak_nv !== want.peak_to_peak_nv) begin
                        $error("peak_to_peak_nv expected %0d got %0d",
                               want.peak_to_peak_nv, m_data.peak_to_peak_nv);
                        err_count++;
                    end
                    if (m_data.stable !== want.stable) begin
                        $error("stable expected %0d got %0d", want.stable, m_data.stable);
                        err_count++;
                    end
                    if (m_data.sensor_faults_out !== want.sensor_faults_out) begin
                        $error("sensor_faults_out expected %0h got %0h",
                               want.sensor_faults_out, m_data.sensor_faults_out);
                        err_count++;
                    end
                    if (m_data.nonfinite_fault !== want.nonfinite_fault) begin
                        $error("nonfinite_fault expected %0d got %0d",
                               want.nonfinite_fault, m_data.nonfinite_fault);
                        err_count++;
                    end
                    if (m_data.transport_fault !== want.transport_fault) begin
                        $error("transport_fault expected %0d got %0d",
                               want.transport_fault, m_data.transport_fault);
                        err_count++;
                    end
                    if (m_data.window_fill !== want.window_fill) begin
                        $error("window_fill expected %0d got %0d",
                               want.window_fill, m_data.window_fill);
                        err_count++;
                    end
                end
            end
            if (s_valid && s_ready) predict_summary(s_data);
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import swsd_pkg::*;

    localparam int SETTLE_CYCLES = 200;    // margin after the last result for a trailing sample to finish
    localparam int IDLE_LIMIT    = 20000;  // covers the long receiver hold-off
    localparam int HOLD_OFF      = 3000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SIMULATED_MODE;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   errors;
    int                   pending;

    // current settings, mirrored here to shape the stimulus
    logic                 cur_mode = 1'b0;
    logic [CFG_W-1:0]     cur_stale = STALE_MS_RESET;
    logic [CFG_W-1:0]     cur_hist = HISTORY_MS_RESET;
    logic [CFG_W-1:0]     cur_limit = LIMIT_NV_RESET;

    // running sample stream
    logic [31:0]          seq_now;
    logic [31:0]          time_now;
    logic [7:0]           gain_now;
    logic signed [31:0]   level;

    always #5 aclk = ~aclk;

    sample_window_stability_detector_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    window_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // Mostly back to back, sometimes a short gap, rarely a long pause.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic in_item_t make_sample(logic act, logic [31:0] sq, logic [31:0] ts,
                                             logic [7:0] g, logic [31:0] v, logic vv,
                                             logic sim, logic w, logic [7:0] f);
        in_item_t it;
        it.action = act;
        it.sequence_req = sq;
        it.sample_time_ms = ts;
        it.gain = g;
        it.voltage_nv = v;
        it.voltage_valid = vv;
        it.simulated = sim;
        it.warmed = w;
        it.sensor_faults_in = f;
        return it;
    endfunction

    // Offer one sample and hold it until the transfer; a zero gap keeps valid high.
    task automatic offer(input in_item_t it, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic good_sample(input int step, input int noise);
        seq_now = seq_now + 1;
        time_now = time_now + step;
        offer(make_sample(1'b0, seq_now, time_now, gain_now,
                          level + $signed($urandom_range(0, 2 * noise)) - noise,
                          1'b1, cur_mode, 1'b1, 8'd0), pick_gap());
    endtask

    // Drain all results and let a trailing clear or repeat finish.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
    endtask

    task automatic configure(input logic md, input logic [CFG_W-1:0] st,
                             input logic [CFG_W-1:0] hi, input logic [CFG_W-1:0] lm);
        drain();
        write_reg(REG_SIMULATED_MODE, {19'd0, md});
        write_reg(REG_STALE_MS, st);
        write_reg(REG_HISTORY_MS, hi);
        write_reg(REG_STABILITY_LIMIT_NV, lm);
        cfg_we <= 1'b0;
        cur_mode = md;
        cur_stale = st;
        cur_hist = hi;
        cur_limit = lm;
    endtask

    // Mostly well-formed runs with random content, plus repeats, gaps and noise.
    task automatic random_phase(input int count);
        int     r, step_max, noise;
        longint lim_step;
        lim_step = longint'(cur_hist) / 8 + 1;
        step_max = (lim_step < longint'(cur_stale)) ? int'(lim_step) : int'(cur_stale);
        if (step_max < 1) step_max = 1;
        seq_now = $urandom();
        time_now = $urandom();
        gain_now = 8'($urandom_range(1, 128));
        level = $urandom();
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            noise = ($urandom_range(0, 3) == 0) ? int'(cur_limit) : int'(cur_limit) / 4;
            if (k % 150 == 149) level = $urandom();
            if (r < 78) begin
                good_sample($urandom_range(1, step_max), noise);
            end else if (r < 82) begin
                // repeat the last sequence number with other content
                offer(make_sample(1'b0, seq_now, $urandom(), 8'($urandom()), $urandom(),
                                  1'b1, cur_mode, 1'b1, 8'd0), pick_gap());
            end else if (r < 85) begin
                good_sample(int'(cur_stale) + $urandom_range(1, 1000), noise);
            end else if (r < 88) begin
                gain_now = 8'($urandom_range(1, 128));
                good_sample(1, noise);
            end else if (r < 95) begin
                seq_now = seq_now + 1;
                time_now = time_now + 1;
                offer(make_sample(1'b0, seq_now, time_now, gain_now, $urandom(),
                                  $urandom_range(0, 3) != 0,
                                  $urandom_range(0, 3) == 0 ? ~cur_mode : cur_mode,
                                  $urandom_range(0, 3) != 0,
                                  $urandom_range(0, 1) ? 8'($urandom()) : 8'd0),
                      pick_gap());
            end else if (r < 97) begin
                offer(make_sample(1'b1, $urandom(), $urandom(), 8'($urandom()), $urandom(),
                                  1'($urandom()), 1'($urandom()), 1'($urandom()),
                                  8'($urandom())),
                      pick_gap());
            end else begin
                offer(make_sample(1'b0, $urandom(), $urandom(), 8'($urandom()), $urandom(),
                                  1'($urandom()), 1'($urandom()), 1'($urandom()),
                                  8'($urandom())),
                      pick_gap());
            end
        end
    endtask

    // Receiver: random stalls, and one long hold-off so the block backs up.
    initial begin
        int stall, taken;
        logic held;
        stall = 0;
        taken = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) taken++;
            if (!held && taken == 300) begin
                held = 1'b1;
                stall = HOLD_OFF;
            end
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 25) begin
                stall = pick_gap();
                m_ready <= stall == 0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing transfers for too long.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings, extremes and each special case.
        gain_now = 8'd1;
        offer(make_sample(1'b0, 32'd1, 32'd0, 8'd1, 32'd0, 1'b1, 1'b0, 1'b1, 8'd0), 0);
        // repeated sequence: dropped
        offer(make_sample(1'b0, 32'd1, 32'd3, 8'd1, 32'd7, 1'b1, 1'b0, 1'b1, 8'd0), 0);
        offer(make_sample(1'b0, 32'd2, 32'd5, 8'd1, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1, 8'd0), 0);
        offer(make_sample(1'b0, 32'd3, 32'd6, 8'd1, 32'h8000_0000, 1'b1, 1'b0, 1'b1, 8'd0), 1);
        // rejects: fault, non-finite, source mismatch, not warmed
        offer(make_sample(1'b0, 32'd4, 32'd7, 8'd1, 32'd55, 1'b1, 1'b0, 1'b1, 8'hFF), 0);
        offer(make_sample(1'b0, 32'd5, 32'd8, 8'd1, -32'sd5, 1'b0, 1'b0, 1'b1, 8'd0), 0);
        offer(make_sample(1'b0, 32'd6, 32'd9, 8'd1, 32'd9, 1'b1, 1'b1, 1'b1, 8'd0), 0);
        offer(make_sample(1'b0, 32'd7, 32'd10, 8'd1, 32'd9, 1'b1, 1'b0, 1'b0, 8'd0), 0);
        offer(make_sample(1'b0, 32'd8, 32'd11, 8'd1, 32'd20, 1'b1, 1'b0, 1'b1, 8'd0), 0);
        // gain change, then a stale gap, then a time wrap
        offer(make_sample(1'b0, 32'd9, 32'd12, 8'd128, 32'd21, 1'b1, 1'b0, 1'b1, 8'd0), 0);
        offer(make_sample(1'b0, 32'd10, 32'd5000, 8'd128, 32'd22, 1'b1, 1'b0, 1'b1, 8'd0), 0);
        offer(make_sample(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 8'd128, 32'd1,
                          1'b1, 1'b0, 1'b1, 8'd0), 0);
        offer(make_sample(1'b0, 32'd0, 32'd5, 8'd128, 32'd2, 1'b1, 1'b0, 1'b1, 8'd0), 0);
        // clear, then the same sequence is taken since nothing is present
        offer(make_sample(1'b1, 32'd0, 32'd6, 8'd128, 32'd3, 1'b1, 1'b0, 1'b1, 8'd0), 0);
        offer(make_sample(1'b0, 32'd0, 32'd10, 8'd128, 32'd4, 1'b1, 1'b0, 1'b1, 8'd0), 0);
        // a quiet run spanning history_ms: stability reached
        seq_now = 32'd100;
        time_now = 32'd20000;
        gain_now = 8'd128;
        level = -32'sd1000;
        for (int k = 0; k < 11; k++) good_sample(1000, 100);

        configure(1'b0, 20'd2000, 20'd100, 20'd10000);
        random_phase(300);
        configure(1'b1, 20'd600000, 20'd600000, 20'd1000000);
        random_phase(300);
        configure(1'b0, 20'd1, 20'd1, 20'd1);
        random_phase(250);
        configure(1'b1, 20'hFFFFF, 20'd0, 20'hFFFFF);
        random_phase(250);
        configure(1'b0, 20'd500, 20'd60, 20'd5000);
        random_phase(400);
        configure(1'b1, 20'd0, 20'hFFFFF, 20'd0);
        random_phase(150);
        configure(1'b0, 20'd3000, 20'd400, 20'd20000);
        random_phase(150);

        drain();
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
